@@ rtl/core/assert_macros.svh @@
// Assertion macros used by dmx512_rx_framer_size_learning_top.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/core/dmxrx_pkg.sv @@
// Types and constants for the DMX512 receive framer with size learning.
// No dependencies.
package dmxrx_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 513;
  localparam int unsigned CNT_W           = 10;
  localparam int unsigned REP_W           = 9;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = 8;

  localparam logic [CNT_W-1:0] MAX_FRAME   = CNT_W'(MAX_FRAME_BYTES);
  localparam logic [CNT_W-1:0] UNLOCK_LEN  = CNT_W'(512);
  localparam logic [REP_W-1:0] REPEAT_MAX  = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_ENABLE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_THRESHOLD = 1'd1;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_AWAIT   = 2'd1,
    PH_COLLECT = 2'd2
  } phase_t;

  typedef struct packed {
    logic             byte_valid;
    logic [CNT_W-1:0] byte_index;
    logic [7:0]       byte_value;
    logic             frame_done;
    logic [CNT_W-1:0] frame_length;
    logic [5:0]       frame_break;
    logic             cut_by_lock;
    logic             lock_held;
    logic [CNT_W-1:0] learned_length;
  } rx_res_t;

endpackage

@@ rtl/core/dmx512_rx_framer_size_learning_top.sv @@
// DMX512 receive framer with frame-size learning.
// Depends on dmxrx_pkg and assert_macros.svh.
//
// Input channel: one receive word per request, either a break marker
// (in_is_break = 1, in_data = break length in us) or a data byte.
// Output channel: at most one result per request, carrying a stored frame
// byte, a finished frame report, or both, with the lock status after it.
// Configuration: cfg_we writes cfg_wdata to register cfg_index
// (0 learn enable, 1 repeat threshold); the user writes only while the
// block is idle, a rule that the block itself leaves unchecked.
//
// Throughput: one request per cycle while in_stall is low.
// A result register plus one skid entry part the channels: requests keep
// being taken while a result waits under out_stall; in_stall rises only
// when the skid entry is occupied, and the result register holds its
// value while stalled.
// Reset (synchronous, rst_n low) empties both result slots, returns the
// framer to idle with no lock, and loads learn enable 1, threshold 20.
module dmx512_rx_framer_size_learning_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_is_break,
  input  logic [7:0]                   in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_byte_valid,
  output logic [dmxrx_pkg::CNT_W-1:0]  out_byte_index,
  output logic [7:0]                   out_byte_value,
  output logic                         out_frame_done,
  output logic [dmxrx_pkg::CNT_W-1:0]  out_frame_length,
  output logic [5:0]                   out_frame_break,
  output logic                         out_cut_by_lock,
  output logic                         out_lock_held,
  output logic [dmxrx_pkg::CNT_W-1:0]  out_learned_length,
  input  logic                         cfg_we,
  input  logic [dmxrx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dmxrx_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dmxrx_pkg::*;

  `include "assert_macros.svh"

  logic             learn_en_r;
  logic [7:0]       thr_r;
  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [5:0]       brk_units_r, brk_units_nxt;
  logic             locked_r, locked_nxt;
  logic [CNT_W-1:0] locked_len_r, locked_len_nxt;
  logic [CNT_W-1:0] prev_len_r, prev_len_nxt;
  logic [REP_W-1:0] rep_r, rep_nxt;

  logic [CNT_W-1:0] cnt_inc;
  logic [REP_W-1:0] rep_inc;
  logic [REP_W-1:0] rep_sel;
  logic             emit;
  rx_res_t          res;

  logic             out_valid_r;
  rx_res_t          out_r;
  logic             skid_valid_r;
  rx_res_t          skid_r;
  logic             in_acc;
  logic             out_take;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_en_r <= 1'b1;
      thr_r      <= 8'd20;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LEARN_ENABLE:     learn_en_r <= cfg_wdata[0];
        CFG_REPEAT_THRESHOLD: thr_r      <= cfg_wdata;
      endcase
    end
  end

  assign cnt_inc = cnt_r + CNT_W'(1);
  assign rep_inc = (rep_r == REPEAT_MAX) ? rep_r : rep_r + REP_W'(1);
  assign rep_sel = (cnt_r == prev_len_r) ? rep_inc : '0;

  always_comb begin
    phase_nxt      = phase_r;
    cnt_nxt        = cnt_r;
    brk_units_nxt  = brk_units_r;
    locked_nxt     = locked_r;
    locked_len_nxt = locked_len_r;
    prev_len_nxt   = prev_len_r;
    rep_nxt        = rep_r;
    emit           = 1'b0;
    res            = '0;
    if (in_is_break) begin
      if (cnt_r != '0) begin
        if (!locked_r) begin
          if (learn_en_r) begin
            rep_nxt = rep_sel;
            if (rep_sel > {1'b0, thr_r}) begin
              locked_nxt     = 1'b1;
              locked_len_nxt = prev_len_r;
            end
            prev_len_nxt = cnt_r;
          end
        end else if (cnt_r != prev_len_r) begin
          locked_nxt     = 1'b0;
          locked_len_nxt = UNLOCK_LEN;
          prev_len_nxt   = UNLOCK_LEN;
          rep_nxt        = '0;
        end
        emit             = 1'b1;
        res.frame_done   = 1'b1;
        res.frame_length = cnt_r;
        res.frame_break  = brk_units_r;
      end
      phase_nxt     = PH_AWAIT;
      brk_units_nxt = in_data[7:2];
      cnt_nxt       = '0;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (locked_r) begin
            locked_nxt     = 1'b0;
            locked_len_nxt = UNLOCK_LEN;
            prev_len_nxt   = UNLOCK_LEN;
            rep_nxt        = '0;
          end
        end
        PH_AWAIT: begin
          if (in_data == 8'd0) begin
            cnt_nxt        = CNT_W'(1);
            phase_nxt      = PH_COLLECT;
            emit           = 1'b1;
            res.byte_valid = 1'b1;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_COLLECT: begin
          if (cnt_r < MAX_FRAME) begin
            emit           = 1'b1;
            res.byte_valid = 1'b1;
            res.byte_index = cnt_r;
            res.byte_value = in_data;
            cnt_nxt        = cnt_inc;
            if (locked_r && cnt_inc == locked_len_r) begin
              res.frame_done   = 1'b1;
              res.frame_length = cnt_inc;
              res.frame_break  = brk_units_r;
              res.cut_by_lock  = 1'b1;
              cnt_nxt          = '0;
              phase_nxt        = PH_IDLE;
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
    res.lock_held      = locked_nxt;
    res.learned_length = locked_len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      cnt_r        <= '0;
      brk_units_r  <= '0;
      locked_r     <= 1'b0;
      locked_len_r <= '0;
      prev_len_r   <= '0;
      rep_r        <= '0;
    end else if (in_acc) begin
      phase_r      <= phase_nxt;
      cnt_r        <= cnt_nxt;
      brk_units_r  <= brk_units_nxt;
      locked_r     <= locked_nxt;
      locked_len_r <= locked_len_nxt;
      prev_len_r   <= prev_len_nxt;
      rep_r        <= rep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (out_valid_r && !out_take) begin
      if (in_acc && emit) begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else begin
      out_valid_r <= in_acc && emit;
      if (in_acc && emit) begin
        out_r <= res;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte_valid     = out_r.byte_valid;
  assign out_byte_index     = out_r.byte_index;
  assign out_byte_value     = out_r.byte_value;
  assign out_frame_done     = out_r.frame_done;
  assign out_frame_length   = out_r.frame_length;
  assign out_frame_break    = out_r.frame_break;
  assign out_cut_by_lock    = out_r.cut_by_lock;
  assign out_lock_held      = out_r.lock_held;
  assign out_learned_length = out_r.learned_length;

  `ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_r || out_valid_r, "skid entry without result")
  `ASSERT_ALWAYS(a_cnt_in_range, cnt_r <= MAX_FRAME, "byte count past frame limit")
  `ASSERT_IMPLY(a_lock_len, locked_r, locked_len_r != '0, "lock held with zero length")
  `ASSERT_IMPLY(a_cut_has_byte, out_valid_r && out_r.cut_by_lock, out_r.byte_valid && out_r.frame_done, "cut frame without its last byte")

endmodule
